[src/positional_list_engine_unit_macros.svh]
// ----------------------------------------------------------------------------
// positional_list_engine_unit_macros
// Assertion helpers for the positional list engine unit.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// checked only while out of reset
`define PLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes, cell control type and reduction tree sizing functions.
// ----------------------------------------------------------------------------
package ple_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// broadcast to every cell, qualified by the target index
	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
	} cell_ctl_t;

	localparam int TREE_FANIN_LOG2 = 3;

	// node count after lvl levels of 8-to-1 reduction
	function automatic int tree_width(input int n, input int lvl);
		int w;
		w = n;
		for (int k = 0; k < lvl; k++) begin
			w = (w + 7) >> TREE_FANIN_LOG2;
		end
		return w;
	endfunction

	// registered levels needed to reduce n leaves to one
	function automatic int tree_levels(input int n);
		int w;
		int l;
		w = (n + 7) >> TREE_FANIN_LOG2;
		l = 1;
		while (w > 1) begin
			w = (w + 7) >> TREE_FANIN_LOG2;
			l++;
		end
		return l;
	endfunction

endpackage

[src/ple_in_if.sv]
// ----------------------------------------------------------------------------
// ple_in_if
// Command channel: opcode, position and data word with valid/ready.
// ----------------------------------------------------------------------------
interface ple_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  position;
	logic [31:0] data_in;

	modport source (output valid, output opcode, output position, output data_in,
		input ready);
	modport sink (input valid, input opcode, input position, input data_in,
		output ready);
endinterface

[src/ple_out_if.sv]
// ----------------------------------------------------------------------------
// ple_out_if
// Result channel: status, read word and element count with valid/ready.
// ----------------------------------------------------------------------------
interface ple_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] read_data;
	logic [6:0]  element_count;

	modport source (output valid, output status, output read_data,
		output element_count, input ready);
	modport sink (input valid, input status, input read_data,
		input element_count, output ready);
endinterface

[src/ple_cell.sv]
// ----------------------------------------------------------------------------
// ple_cell
// One storage slot of the list; holds, loads, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module ple_cell #(
	parameter int W   = 32,
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  ple_pkg::cell_ctl_t     ctl,
	input  logic [IW-1:0]          tgt,
	input  logic [W-1:0]           word,
	input  logic [W-1:0]           prev_word,
	input  logic [W-1:0]           next_word,
	output logic [W-1:0]           value,
	output logic [W-1:0]           rd_word
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [W-1:0] data_q;
	logic         at_or_after;
	logic         hit;

	assign at_or_after = MY_IDX >= tgt;
	assign hit         = MY_IDX == tgt;
	assign value       = data_q;
	assign rd_word     = (ctl.rd && hit) ? data_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.ins && at_or_after) begin
			data_q <= hit ? word : prev_word;
		end else if (ctl.del && at_or_after) begin
			data_q <= next_word;
		end
	end

endmodule

[src/ple_or_tree.sv]
// ----------------------------------------------------------------------------
// ple_or_tree
// Registered 8-to-1 OR reduction that collects the selected cell's word.
// ----------------------------------------------------------------------------
module ple_or_tree #(
	parameter int N = 64,
	parameter int W = 32
) (
	input  logic         clk,
	input  logic [W-1:0] leaves [N],
	output logic [W-1:0] root
);

	localparam int LEVELS = ple_pkg::tree_levels(N);

	// registered nodes of each level, and the zero padded inputs of each level
	logic [W-1:0] node_q [LEVELS][N];
	logic [W-1:0] din    [LEVELS][N*8];

	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		localparam int NI = ple_pkg::tree_width(N, l);
		for (genvar k = 0; k < N * 8; k++) begin : g_in
			if (k >= NI) begin : g_pad
				assign din[l][k] = '0;
			end else if (l == 0) begin : g_leaf
				assign din[l][k] = leaves[k];
			end else begin : g_node
				assign din[l][k] = node_q[l-1][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LEVELS; l++) begin
			for (int j = 0; j < N; j++) begin
				node_q[l][j] <= din[l][8*j]   | din[l][8*j+1] | din[l][8*j+2] |
					din[l][8*j+3] | din[l][8*j+4] | din[l][8*j+5] |
					din[l][8*j+6] | din[l][8*j+7];
			end
		end
	end

	assign root = node_q[LEVELS-1][0];

endmodule

[src/positional_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of up to DEPTH words with insert, delete and read at a position.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells; an insert moves every cell at or
// past the position back by one and loads the new word, a delete pulls the
// following cells forward, both across all cells together. Status and count
// are settled on acceptance; reads gather the addressed word through a
// registered 8-to-1 OR tree with L = ceil(log8(DEPTH)) levels. One command
// is in flight at a time: its result passes the command register, the tree
// levels and the output register, and the next command is taken in the
// cycle that result is handed off, so no new command enters while an
// earlier one is still in the engine.
module positional_list_engine_unit #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	ple_in_if.sink   cmd,
	ple_out_if.source rsp
);

	`include "positional_list_engine_unit_macros.svh"

	localparam int IW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int PW     = ((CW > 8) ? CW : 8) + 1;
	localparam int LEVELS = ple_pkg::tree_levels(DEPTH);

	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	// control state
	logic [CW-1:0]        count_q;
	logic [LEVELS:0]      vld_q;
	logic                 out_vld_q;
	ple_pkg::cell_ctl_t   ctl_s1;

	// payload
	logic [IW-1:0]         tgt_s1;
	logic [DATA_WIDTH-1:0] word_s1;
	ple_pkg::status_t      status_q;
	ple_pkg::status_t      out_status_q;
	logic [31:0]           out_data_q;
	logic [6:0]            out_count_q;

	logic                 accept;
	ple_pkg::status_t     status_d;
	ple_pkg::cell_ctl_t   ctl_d;
	logic [CW-1:0]        count_d;
	logic [PW-1:0]        pos_ext;
	logic [PW-1:0]        cnt_ext;
	logic [7:0]           pos_m1;
	logic                 pos_zero;

	logic [DATA_WIDTH-1:0] cell_val [DEPTH];
	logic [DATA_WIDTH-1:0] cell_rd  [DEPTH];
	logic [DATA_WIDTH-1:0] rd_root;

	assign cmd.ready = (vld_q == '0) && (!out_vld_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;

	assign pos_ext  = PW'(cmd.position);
	assign cnt_ext  = PW'(count_q);
	assign pos_m1   = cmd.position - 8'd1;
	assign pos_zero = cmd.position == 8'd0;

	always_comb begin
		status_d = ple_pkg::ST_BADPOS;
		ctl_d    = '0;
		count_d  = count_q;
		unique case (cmd.opcode)
			ple_pkg::OP_INSERT: begin
				if (count_q == FULL_COUNT) begin
					status_d = ple_pkg::ST_FULL;
				end else if (!pos_zero && pos_ext <= cnt_ext + PW'(1)) begin
					status_d  = ple_pkg::ST_OK;
					ctl_d.ins = 1'b1;
					count_d   = count_q + CW'(1);
				end
			end
			ple_pkg::OP_DELETE: begin
				if (!pos_zero && pos_ext <= cnt_ext) begin
					status_d  = ple_pkg::ST_OK;
					ctl_d.del = 1'b1;
					count_d   = count_q - CW'(1);
				end
			end
			ple_pkg::OP_READ: begin
				if (!pos_zero && pos_ext <= cnt_ext) begin
					status_d = ple_pkg::ST_OK;
					ctl_d.rd = 1'b1;
				end
			end
			default: begin
				status_d = ple_pkg::ST_BADPOS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			vld_q     <= '0;
			ctl_s1    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[LEVELS-1:0], accept};
			ctl_s1 <= accept ? ctl_d : '0;
			if (accept) begin
				count_q <= count_d;
			end
			if (vld_q[LEVELS]) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_s1   <= IW'(pos_m1);
			word_s1  <= DATA_WIDTH'(cmd.data_in);
			status_q <= status_d;
		end
		if (vld_q[LEVELS]) begin
			out_status_q <= status_q;
			out_data_q   <= 32'(rd_root);
			out_count_q  <= 7'(count_q);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = word_s1;
		end else begin : g_prev
			assign prev_w = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_w = cell_val[i];
		end else begin : g_next
			assign next_w = cell_val[i+1];
		end
		ple_cell #(
			.W   (DATA_WIDTH),
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl_s1),
			.tgt       (tgt_s1),
			.word      (word_s1),
			.prev_word (prev_w),
			.next_word (next_w),
			.value     (cell_val[i]),
			.rd_word   (cell_rd[i])
		);
	end

	ple_or_tree #(
		.N (DEPTH),
		.W (DATA_WIDTH)
	) u_tree (
		.clk    (clk),
		.leaves (cell_rd),
		.root   (rd_root)
	);

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_status_q;
	assign rsp.read_data     = out_data_q;
	assign rsp.element_count = out_count_q;

	`PLE_ASSERT(a_count_bound, count_q <= FULL_COUNT, "element count above depth")
	`PLE_ASSERT(a_one_in_flight, $onehot0(vld_q), "more than one command in flight")
	`PLE_ASSERT(a_count_moves_on_accept, count_q != $past(count_q) |-> $past(accept),
		"count changed without a request")
	`PLE_ASSERT(a_full_status_count,
		rsp.valid && rsp.status == ple_pkg::ST_FULL |-> rsp.element_count == 7'(DEPTH),
		"full status with list not full")
	`PLE_ASSERT(a_read_data_zero,
		rsp.valid && rsp.status != ple_pkg::ST_OK |-> rsp.read_data == '0,
		"read data on failed request")

endmodule

[bench/positional_list_engine_unit_test.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_unit_test
// Self-checking bench for the positional list engine: a directed table of
// edge cases, then a fill to full and random grow, shrink and mixed phases
// checked against a behavioral list model, with bursty requests and a
// stalling result sink.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 64;
	localparam int ITEM_TARGET = 1700;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLDOFF_CYCLES = 400;
	// opcode with no meaning, must answer invalid position
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		ple_pkg::status_t status;
		logic [31:0]      read_data;
		logic [6:0]       count;
	} list_result_t;

	typedef struct packed {
		logic [1:0]   op;
		logic [7:0]   pos;
		logic [31:0]  data;
		logic         typed;
		list_result_t res;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 23;

	// expected result typed in only where typed is set
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{ple_pkg::OP_READ, 8'd1, 32'h0, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd0}},
		'{ple_pkg::OP_DELETE, 8'd1, 32'h0, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd0}},
		'{ple_pkg::OP_INSERT, 8'd0, 32'h1, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd0}},
		'{ple_pkg::OP_INSERT, 8'd2, 32'h1, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd0}},
		'{OP_UNUSED, 8'd1, 32'h1, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd0}},
		'{ple_pkg::OP_INSERT, 8'd1, 32'hFFFFFFFF, 1'b1, '{ple_pkg::ST_OK, 32'h0, 7'd1}},
		'{ple_pkg::OP_READ, 8'd1, 32'h0, 1'b1, '{ple_pkg::ST_OK, 32'hFFFFFFFF, 7'd1}},
		'{ple_pkg::OP_INSERT, 8'd2, 32'h0, 1'b1, '{ple_pkg::ST_OK, 32'h0, 7'd2}},
		'{ple_pkg::OP_INSERT, 8'd1, 32'hA5A5A5A5, 1'b1, '{ple_pkg::ST_OK, 32'h0, 7'd3}},
		'{ple_pkg::OP_INSERT, 8'd4, 32'h5A5A5A5A, 1'b1, '{ple_pkg::ST_OK, 32'h0, 7'd4}},
		'{ple_pkg::OP_INSERT, 8'd6, 32'h1, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd4}},
		'{ple_pkg::OP_READ, 8'd255, 32'h0, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd4}},
		'{ple_pkg::OP_READ, 8'd0, 32'h0, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd4}},
		'{ple_pkg::OP_READ, 8'd4, 32'hFFFFFFFF, 1'b1, '{ple_pkg::ST_OK, 32'h5A5A5A5A, 7'd4}},
		'{ple_pkg::OP_READ, 8'd5, 32'h0, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd4}},
		'{ple_pkg::OP_DELETE, 8'd5, 32'h0, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd4}},
		'{ple_pkg::OP_INSERT, 8'd3, 32'h12345678, 1'b0, '{ple_pkg::ST_OK, 32'h0, 7'd0}},
		'{ple_pkg::OP_READ, 8'd3, 32'h0, 1'b0, '{ple_pkg::ST_OK, 32'h0, 7'd0}},
		'{ple_pkg::OP_DELETE, 8'd1, 32'h0, 1'b0, '{ple_pkg::ST_OK, 32'h0, 7'd0}},
		'{ple_pkg::OP_DELETE, 8'd4, 32'hFFFFFFFF, 1'b0, '{ple_pkg::ST_OK, 32'h0, 7'd0}},
		'{ple_pkg::OP_READ, 8'd1, 32'hFFFFFFFF, 1'b0, '{ple_pkg::ST_OK, 32'h0, 7'd0}},
		'{OP_UNUSED, 8'd255, 32'hFFFFFFFF, 1'b1, '{ple_pkg::ST_BADPOS, 32'h0, 7'd3}},
		'{ple_pkg::OP_DELETE, 8'd2, 32'h0, 1'b0, '{ple_pkg::ST_OK, 32'h0, 7'd0}}
	};

	logic clk;
	logic arst_n;

	ple_in_if  cmd_ch();
	ple_out_if rsp_ch();

	positional_list_engine_unit #(
		.DEPTH      (LIST_DEPTH),
		.DATA_WIDTH (32)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// list model state
	logic [31:0] list_words [0:LIST_DEPTH-1];
	int          list_len;

	list_result_t pending_results [$];
	int           mismatch_count;
	int           results_checked;
	int           commands_sent;
	int           burst_left;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic list_result_t predict_list_op(input logic [1:0] op,
		input logic [7:0] pos, input logic [31:0] word);
		list_result_t r;
		int p;
		int i;
		p = pos;
		r.status = ple_pkg::ST_OK;
		r.read_data = '0;
		case (op)
			ple_pkg::OP_INSERT: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = ple_pkg::ST_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					r.status = ple_pkg::ST_BADPOS;
				end else begin
					for (i = list_len; i >= p; i--) list_words[i] = list_words[i-1];
					list_words[p-1] = word;
					list_len++;
				end
			end
			ple_pkg::OP_DELETE: begin
				if (p < 1 || p > list_len) begin
					r.status = ple_pkg::ST_BADPOS;
				end else begin
					for (i = p; i < list_len; i++) list_words[i-1] = list_words[i];
					list_len--;
				end
			end
			ple_pkg::OP_READ: begin
				if (p < 1 || p > list_len) r.status = ple_pkg::ST_BADPOS;
				else r.read_data = list_words[p-1];
			end
			default: begin
				r.status = ple_pkg::ST_BADPOS;
			end
		endcase
		r.count = list_len[6:0];
		return r;
	endfunction

	function automatic stim_row_t free_row(input logic [1:0] op, input logic [7:0] pos,
		input logic [31:0] data);
		stim_row_t row;
		row.op = op;
		row.pos = pos;
		row.data = data;
		row.typed = 1'b0;
		row.res = '{ple_pkg::ST_OK, 32'h0, 7'd0};
		return row;
	endfunction

	// mostly in range, some at the ends, some anywhere in the field
	function automatic logic [7:0] pick_position(input logic [1:0] op);
		int lim;
		int r;
		lim = (op == ple_pkg::OP_INSERT) ? list_len + 1 : list_len;
		if (lim < 1) lim = 1;
		r = $urandom_range(0, 99);
		if (r < 10) return 8'($urandom_range(0, 255));
		if (r < 13) return 8'd1;
		if (r < 16) return 8'(lim);
		return 8'($urandom_range(1, lim));
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h0;
		if (r == 1) return 32'hFFFFFFFF;
		return $urandom;
	endfunction

	// bursts of random length, gaps carry junk on the payload
	task automatic send_command(input stim_row_t row);
		int gap;
		list_result_t predicted;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				cmd_ch.valid <= 1'b0;
				cmd_ch.opcode <= 2'($urandom);
				cmd_ch.position <= 8'($urandom);
				cmd_ch.data_in <= $urandom;
				@(posedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= row.op;
		cmd_ch.position <= row.pos;
		cmd_ch.data_in <= row.data;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		predicted = predict_list_op(row.op, row.pos, row.data);
		pending_results.push_back(row.typed ? row.res : predicted);
		commands_sent++;
	endtask

	initial begin : stimulus
		int phase;
		int r;
		int ins_cut;
		int del_cut;
		logic [1:0] op;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = '0;
		cmd_ch.position = '0;
		cmd_ch.data_in = '0;
		list_len = 0;
		mismatch_count = 0;
		results_checked = 0;
		commands_sent = 0;
		burst_left = 0;
		for (int k = 0; k < LIST_DEPTH; k++) list_words[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIRECTED_ROWS; k++) send_command(directed_rows[k]);

		// fill to the top, then poke at a full list
		while (list_len < LIST_DEPTH)
			send_command(free_row(ple_pkg::OP_INSERT, 8'($urandom_range(1, list_len + 1)),
				pick_word()));
		send_command(free_row(ple_pkg::OP_INSERT, 8'd0, 32'h1));
		send_command(free_row(ple_pkg::OP_INSERT, 8'd1, 32'h1));
		send_command(free_row(ple_pkg::OP_INSERT, 8'd65, 32'h1));
		send_command(free_row(ple_pkg::OP_INSERT, 8'd255, 32'h1));
		send_command(free_row(ple_pkg::OP_READ, 8'd64, 32'h0));
		send_command(free_row(ple_pkg::OP_READ, 8'd65, 32'h0));
		send_command(free_row(ple_pkg::OP_DELETE, 8'd64, 32'h0));
		send_command(free_row(ple_pkg::OP_INSERT, 8'd64, 32'hFFFFFFFF));
		send_command(free_row(ple_pkg::OP_DELETE, 8'd1, 32'h0));

		while (commands_sent < ITEM_TARGET) begin
			phase = $urandom_range(0, 2);
			case (phase)
				0: begin ins_cut = 70; del_cut = 85; end  // grow
				1: begin ins_cut = 20; del_cut = 85; end  // shrink
				default: begin ins_cut = 40; del_cut = 65; end
			endcase
			repeat ($urandom_range(20, 120)) begin
				r = $urandom_range(0, 99);
				if (r < 5) op = OP_UNUSED;
				else if (r < ins_cut) op = ple_pkg::OP_INSERT;
				else if (r < del_cut) op = ple_pkg::OP_DELETE;
				else op = ple_pkg::OP_READ;
				send_command(free_row(op, pick_position(op), pick_word()));
			end
		end

		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// result sink: segments of steady, random and periodic stalls, one long hold
	initial begin : result_sink
		int seg_left;
		int mode;
		int hold_left;
		int tick;
		bit hold_done;
		rsp_ch.ready = 1'b0;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		tick = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 150);
				mode = $urandom_range(0, 3);
				if (!hold_done && results_checked >= 300) begin
					hold_left = HOLDOFF_CYCLES;
					hold_done = 1'b1;
				end
			end
			seg_left--;
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= (tick % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					mismatch_count++;
				end
				if (rsp_ch.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, rsp_ch.read_data);
					mismatch_count++;
				end
				if (rsp_ch.element_count !== want.count) begin
					$error("element_count: expected %0d, got %0d", want.count,
						rsp_ch.element_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[positional_list_engine_unit.f]
+incdir+src
src/ple_pkg.sv
src/ple_in_if.sv
src/ple_out_if.sv
src/ple_cell.sv
src/ple_or_tree.sv
src/positional_list_engine_unit.sv
bench/positional_list_engine_unit_test.sv
